// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with asynchronous active-low reset gating.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: sv/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types, constants and helpers of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

	// Field widths
	localparam int unsigned CODE_W = 21;
	localparam int unsigned BYTE_W = 8;

	// Default replacement code point ('?')
	localparam logic [CODE_W-1:0] REPL_RESET = 21'd63;

	// Byte classes
	localparam logic [1:0]        CONT_TAG     = 2'b10;
	localparam logic [BYTE_W-1:0] LEAD_3       = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD_4       = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD_INVALID = 8'hF8;

	// Code point limits
	localparam logic [CODE_W-1:0] MIN_2    = 21'h00080;
	localparam logic [CODE_W-1:0] MIN_3    = 21'h00800;
	localparam logic [CODE_W-1:0] MIN_4    = 21'h10000;
	localparam logic [CODE_W-1:0] MAX_CODE = 21'h10FFFF;
	localparam logic [CODE_W-1:0] SURR_LO  = 21'h0D800;
	localparam logic [CODE_W-1:0] SURR_HI  = 21'h0DFFF;

	// Form lengths in bytes
	localparam logic [2:0] FLEN_2 = 3'd2;
	localparam logic [2:0] FLEN_3 = 3'd3;
	localparam logic [2:0] FLEN_4 = 3'd4;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_REPLAY = 2'b10
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic step;       // run one decode step this cycle
		logic use_queue;  // step byte comes from the replay queue
		logic run_end;    // no more steps for the current item after this one
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic can_push;   // output register can take a result this cycle
		logic q_more;     // replay queue nonempty after this step
		logic q_busy;     // replay queue nonempty now
	} ctrl_sts_t;

	function automatic logic is_cont(input logic [BYTE_W-1:0] b);
		return b[7:6] == CONT_TAG;
	endfunction

	function automatic logic [2:0] form_len(input logic [BYTE_W-1:0] lead);
		if (lead < LEAD_3) begin
			return FLEN_2;
		end
		if (lead < LEAD_4) begin
			return FLEN_3;
		end
		return FLEN_4;
	endfunction

endpackage

// File: sv/u8dec_ctrl.sv
// ----------------------------------------------------------------------------
// u8dec_ctrl
// Sequencer: takes input items and runs the replay steps that follow them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8dec_ctrl
	import u8dec_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_axis_tvalid,
	output logic      s_axis_tready,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// Handshake and step commands
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && sts.can_push;
		cmd           = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.step      = s_axis_tvalid && sts.can_push;
				cmd.use_queue = 1'b0;
			end
			ST_REPLAY: begin
				cmd.step      = sts.can_push;
				cmd.use_queue = 1'b1;
			end
			default: begin
				cmd.step      = 1'b0;
				cmd.use_queue = 1'b0;
			end
		endcase
		cmd.run_end = cmd.step && !sts.q_more;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		if (cmd.step) begin
			state_d = sts.q_more ? ST_REPLAY : ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ASSERT_PROP(a_idle_queue_empty, clk, arst_n, (state_q == ST_IDLE) |-> !sts.q_busy, "idle with replay queue busy")
	`ASSERT_PROP(a_step_has_room, clk, arst_n, cmd.step |-> sts.can_push, "step without output room")
	`ASSERT_PROP(a_run_end_idle, clk, arst_n, (cmd.step && !sts.q_more) |=> (state_q == ST_IDLE), "not idle after run end")

endmodule

// File: sv/u8dec_datapath.sv
// ----------------------------------------------------------------------------
// u8dec_datapath
// Decode step unit, held form bytes, replay queue, result hold and output
// register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8dec_datapath
	import u8dec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CODE_W-1:0] cfg_wdata,
	input  logic [7:0]        s_axis_tdata,
	input  logic              s_axis_tlast,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,
	output logic              m_axis_tuser,
	output logic              m_axis_tlast,
	input  ctrl_cmd_t         cmd,
	output ctrl_sts_t         sts
);

	// Configuration
	logic [CODE_W-1:0] repl_q;

	// Decoder state
	logic [BYTE_W-1:0] pend_q [3];
	logic [1:0]        pc_q;
	logic              skip_q;

	// Replay queue
	logic [BYTE_W-1:0] qb_q [3];
	logic              qe_q [3];
	logic [1:0]        qn_q;

	// Result hold and output register
	logic              hold_v_q;
	logic              hold_done_q;
	logic              hold_rep_q;
	logic [CODE_W-1:0] hold_code_q;
	logic              m_valid_q;
	logic              m_rep_q;
	logic              m_last_q;
	logic [CODE_W-1:0] m_code_q;

	// Step signals
	logic [BYTE_W-1:0] cur_b;
	logic              cur_e;
	logic [2:0]        flen;
	logic [BYTE_W-1:0] tail [3];
	logic              bad;
	logic [CODE_W-1:0] dec;
	logic              dec_ok;
	logic              emit;
	logic              emit_rep;
	logic [CODE_W-1:0] emit_code;
	logic              skip_d;
	logic [1:0]        pc_d;
	logic              pend_we;
	logic [1:0]        pend_wi;
	logic              replay;
	logic [BYTE_W-1:0] qb_d [3];
	logic              qe_d [3];
	logic [1:0]        qn_d;
	logic [1:0]        rest_n;
	logic              can_push;
	logic              hold_flush;

	assign can_push   = !m_valid_q || m_axis_tready;
	assign hold_flush = hold_v_q && (hold_done_q || (cmd.step && emit));

	// Step byte source
	assign cur_b = cmd.use_queue ? qb_q[0] : s_axis_tdata;
	assign cur_e = cmd.use_queue ? qe_q[0] : s_axis_tlast;
	assign flen  = form_len(pend_q[0]);

	// Tail of a complete form: held bytes after the lead, then the step byte
	always_comb begin
		tail[0] = (pc_q >= 2'd2) ? pend_q[1] : cur_b;
		tail[1] = (pc_q == 2'd3) ? pend_q[2] : cur_b;
		tail[2] = cur_b;
		bad     = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if ((2'(i) < pc_q) && !is_cont(tail[i])) begin
				bad = 1'b1;
			end
		end
	end

	// Value of a complete form and its range check
	always_comb begin
		case (flen)
			FLEN_2: begin
				dec    = {10'd0, pend_q[0][4:0], cur_b[5:0]};
				dec_ok = dec >= MIN_2;
			end
			FLEN_3: begin
				dec    = {5'd0, pend_q[0][3:0], pend_q[1][5:0], cur_b[5:0]};
				dec_ok = (dec >= MIN_3) && !((dec >= SURR_LO) && (dec <= SURR_HI));
			end
			default: begin
				dec    = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], cur_b[5:0]};
				dec_ok = (dec >= MIN_4) && (dec <= MAX_CODE);
			end
		endcase
	end

	// One decode step
	always_comb begin
		emit     = 1'b0;
		emit_rep = 1'b0;
		skip_d   = skip_q;
		pc_d     = pc_q;
		pend_we  = 1'b0;
		pend_wi  = pc_q;
		replay   = 1'b0;
		if (skip_q && is_cont(cur_b)) begin
			// swallowed continuation
			if (cur_e) begin
				skip_d = 1'b0;
			end
		end else begin
			skip_d = 1'b0;
			if (pc_q == 2'd0) begin
				if (!cur_b[7]) begin
					emit = 1'b1;
				end else if (is_cont(cur_b)) begin
					emit     = 1'b1;
					emit_rep = 1'b1;
					skip_d   = !cur_e;
				end else if (cur_b >= LEAD_INVALID) begin
					emit     = 1'b1;
					emit_rep = 1'b1;
				end else begin
					pend_we = 1'b1;
					pend_wi = 2'd0;
					pc_d    = 2'd1;
					if (cur_e) begin
						emit     = 1'b1;
						emit_rep = 1'b1;
						pc_d     = 2'd0;
					end
				end
			end else if (({1'b0, pc_q} + 3'd1) < flen) begin
				// form still incomplete
				pend_we = 1'b1;
				pc_d    = pc_q + 2'd1;
				if (cur_e) begin
					emit     = 1'b1;
					emit_rep = 1'b1;
					pc_d     = 2'd0;
				end
			end else begin
				pc_d     = 2'd0;
				emit     = 1'b1;
				emit_rep = bad || !dec_ok;
				replay   = bad;
			end
		end
		emit_code = emit_rep ? repl_q :
			((pc_q == 2'd0) ? {13'd0, cur_b} : dec);
	end

	// Replay queue update
	always_comb begin
		rest_n = cmd.use_queue ? (qn_q - 2'd1) : 2'd0;
		for (int i = 0; i < 3; i++) begin
			qb_d[i] = qb_q[i];
			qe_d[i] = qe_q[i];
		end
		qn_d = qn_q;
		if (cmd.step) begin
			if (replay) begin
				qn_d = pc_q + rest_n;
				case (pc_q)
					2'd2: begin
						qb_d[0] = tail[0]; qe_d[0] = 1'b0;
						qb_d[1] = tail[1]; qe_d[1] = cur_e;
						qb_d[2] = qb_q[1]; qe_d[2] = qe_q[1];
					end
					2'd3: begin
						qb_d[0] = tail[0]; qe_d[0] = 1'b0;
						qb_d[1] = tail[1]; qe_d[1] = 1'b0;
						qb_d[2] = tail[2]; qe_d[2] = cur_e;
					end
					default: begin
						qb_d[0] = tail[0]; qe_d[0] = cur_e;
						qb_d[1] = qb_q[1]; qe_d[1] = qe_q[1];
						qb_d[2] = qb_q[2]; qe_d[2] = qe_q[2];
					end
				endcase
			end else begin
				qn_d    = rest_n;
				qb_d[0] = qb_q[1]; qe_d[0] = qe_q[1];
				qb_d[1] = qb_q[2]; qe_d[1] = qe_q[2];
			end
		end
	end

	always_comb begin
		sts.can_push = can_push;
		sts.q_more   = qn_d != 2'd0;
		sts.q_busy   = qn_q != 2'd0;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q      <= REPL_RESET;
			pc_q        <= 2'd0;
			skip_q      <= 1'b0;
			qn_q        <= 2'd0;
			hold_v_q    <= 1'b0;
			hold_done_q <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				repl_q <= cfg_wdata;
			end
			if (cmd.step) begin
				pc_q   <= pc_d;
				skip_q <= skip_d;
			end
			qn_q <= qn_d;
			// hold: newest result, flushed when the next one arrives or the run ends
			if (cmd.step && emit) begin
				hold_v_q    <= 1'b1;
				hold_done_q <= cmd.run_end;
			end else if (hold_flush && can_push) begin
				hold_v_q    <= 1'b0;
				hold_done_q <= 1'b0;
			end else if (cmd.step && cmd.run_end) begin
				hold_done_q <= hold_v_q;
			end
			// output register
			if (can_push) begin
				m_valid_q <= hold_flush;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.step && pend_we) begin
			pend_q[pend_wi] <= cur_b;
		end
		for (int i = 0; i < 3; i++) begin
			qb_q[i] <= qb_d[i];
			qe_q[i] <= qe_d[i];
		end
		if (cmd.step && emit) begin
			hold_code_q <= emit_code;
			hold_rep_q  <= emit_rep;
		end
		if (can_push && hold_flush) begin
			m_code_q <= hold_code_q;
			m_rep_q  <= hold_rep_q;
			m_last_q <= hold_done_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'd0, m_code_q};
	assign m_axis_tuser  = m_rep_q;
	assign m_axis_tlast  = m_last_q;

	`ASSERT_NEVER(a_skip_no_form, clk, arst_n, skip_q && (pc_q != 2'd0), "skipping while a form is held")
	`ASSERT_PROP(a_done_needs_hold, clk, arst_n, hold_done_q |-> hold_v_q, "run end marked on empty hold")
	`ASSERT_PROP(a_held_lead_ok, clk, arst_n, (pc_q != 2'd0) |-> ((pend_q[0][7:6] == 2'b11) && (pend_q[0] < LEAD_INVALID)), "held byte is not a valid lead")

endmodule

// File: sv/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point stream, with configurable replacement code.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and gives code points, one result per cycle at
// most. A byte is taken only when the replay queue is empty and the output
// side can move. A byte that completes a form with a bad tail puts the tail
// bytes (up to three, itself included) back into the queue, and each of them
// then goes through the shared decode step again; a replayed byte may in
// turn complete a shorter form with a bad tail. Each result sits in a hold
// register until it is known whether it ends its item's run (tlast): the last
// result of an item moves on to the output register when the output can
// move, while an earlier result of the same item waits in the hold register
// for the next one. Bytes that only complete part of a form without tlast,
// or are swallowed, give no result. The replacement code may only be
// written while no item is in flight.

module utf8_stream_decoder
	import u8dec_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [CODE_W-1:0] cfg_wdata,      // replacement_code
	// byte input
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [7:0]        s_axis_tdata,   // [7:0] in_byte
	input  logic              s_axis_tlast,   // end_of_string
	// code point output
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [23:0]       m_axis_tdata,   // [20:0] code_point, [23:21] zero
	output logic              m_axis_tuser,   // [0] is_replacement
	output logic              m_axis_tlast    // last_of_run
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	u8dec_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	u8dec_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule
